### src/gpl_pkg.sv
`default_nettype none

package gpl_pkg;

  // Fixed field widths of the block's ports.
  localparam int DATA_W = 64;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;
  localparam int TOT_W  = 7;

  // Defaults for the top-level parameters.
  localparam int MAX_GENES_DEF   = 64;
  localparam int MAX_MEMBERS_DEF = 64;

  // Register indexes of the configuration port.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_PAIR_THRESHOLD = 1'b0;
  localparam cfg_idx_t REG_GENE_COUNT     = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] THRESHOLD_RESET  = 7'd1;
  localparam logic [CFG_W-1:0] GENE_COUNT_RESET = 7'd64;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_CNT,
    S_CNT_DRAIN,
    S_LOCK,
    S_LOCK_DRAIN,
    S_OUT_RD,
    S_OUT_WAIT
  } state_t;

  // Data-stage control shared by both store units.
  typedef struct packed {
    logic cnt_clr;
    logic cnt_en;
    logic lock_en;
    logic first_pass;
    logic last_pass;
  } ctl_t;

endpackage

`default_nettype wire

### src/gpl_member_unit.sv
`default_nettype none

module gpl_member_unit #(
  parameter int MAX_MEMBERS = 64,
  parameter int AW          = 6,
  parameter int CW          = 7,
  parameter int PW          = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [gpl_pkg::DATA_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire gpl_pkg::ctl_t             ctl,
  input  wire logic [PW-1:0]             pos,
  output logic [CW-1:0]                  pair_count
);
  import gpl_pkg::*;

  logic [DATA_W-1:0] mem [MAX_MEMBERS];
  logic [DATA_W-1:0] member_q;
  logic [DATA_W-1:0] shifted;
  logic [1:0]        pair;
  logic [CW-1:0]     counters [4];

  // Chromosome memory: one word per member, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      member_q <= mem[rd_addr];
    end
  end

  // Gene at the current position is the high bit of the pattern.
  always_comb begin
    shifted = member_q >> pos;
    pair    = {shifted[0], shifted[1]};
  end

  assign pair_count = counters[pair];

  // Pattern counters, cleared at the start of each counting pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        counters[i] <= '0;
      end
    end else if (ctl.cnt_clr) begin
      for (int i = 0; i < 4; i++) begin
        counters[i] <= '0;
      end
    end else if (ctl.cnt_en) begin
      counters[pair] <= counters[pair] + 1'b1;
    end
  end

endmodule

`default_nettype wire

### src/gpl_mask_unit.sv
`default_nettype none

module gpl_mask_unit #(
  parameter int MAX_MEMBERS = 64,
  parameter int MAX_GENES   = 64,
  parameter int AW          = 6,
  parameter int CW          = 7,
  parameter int PW          = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire gpl_pkg::ctl_t              ctl,
  input  wire logic [PW-1:0]              pos,
  input  wire logic [CW-1:0]              pair_count,
  input  wire logic [gpl_pkg::CFG_W-1:0]  pair_threshold,
  output logic [MAX_GENES-1:0]            mask_q,
  output logic [gpl_pkg::TOT_W-1:0]       total_q,
  output logic [AW-1:0]                   best
);
  import gpl_pkg::*;

  localparam int WORD_W = MAX_GENES + TOT_W;
  localparam int CMP_W  = (CW > CFG_W) ? CW : CFG_W;

  logic [WORD_W-1:0]    mem [MAX_MEMBERS];
  logic [WORD_W-1:0]    rdq;
  logic [MAX_GENES-1:0] old_mask;
  logic [MAX_GENES-1:0] new_mask;
  logic [TOT_W-1:0]     old_total;
  logic [TOT_W-1:0]     new_total;
  logic [TOT_W-1:0]     best_total;
  logic                 hit;

  assign mask_q  = rdq[MAX_GENES-1:0];
  assign total_q = rdq[WORD_W-1:MAX_GENES];

  // Lock decision; the first pass starts from a cleared mask and count.
  always_comb begin
    old_mask  = ctl.first_pass ? '0 : rdq[MAX_GENES-1:0];
    old_total = ctl.first_pass ? '0 : rdq[WORD_W-1:MAX_GENES];
    hit       = !old_mask[pos] &&
                (CMP_W'(pair_count) >= CMP_W'(pair_threshold));
    new_mask  = hit ? (old_mask | (MAX_GENES'(2'b11) << pos)) : old_mask;
    new_total = hit ? (old_total + TOT_W'(2)) : old_total;
  end

  // Mask and count memory: each entry is written back in the cycle after its read.
  always_ff @(posedge clk) begin
    if (ctl.lock_en) begin
      mem[wr_addr] <= {new_total, new_mask};
    end
    if (rd_en) begin
      rdq <= mem[rd_addr];
    end
  end

  // On the last pass the totals are final; keep the first greatest one.
  always_ff @(posedge clk) begin
    if (ctl.lock_en && ctl.last_pass &&
        ((wr_addr == '0) || (new_total > best_total))) begin
      best       <= wr_addr;
      best_total <= new_total;
    end
  end

endmodule

`default_nettype wire

### src/gene_pair_linkage_mask.sv
// Loading stores one word per handshake; the word that closes the population starts
// the build when G >= 2 genes are in use. The build runs G-1 passes: a counting sweep
// and a read-modify-write sweep over the mask memory, each one read per cycle.
// Results follow one per member, each held until it is taken, then loading resumes.
// Synchronous active-high reset returns to loading with an empty population and the
// registers at threshold 1 and 64 genes; the memories are not cleared.
`default_nettype none

module gene_pair_linkage_mask #(
  parameter int MAX_GENES   = gpl_pkg::MAX_GENES_DEF,
  parameter int MAX_MEMBERS = gpl_pkg::MAX_MEMBERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [gpl_pkg::DATA_W-1:0] chromosome_bits,
  input  wire logic                       final_member,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [gpl_pkg::IDX_W-1:0]       member_index,
  output logic [gpl_pkg::DATA_W-1:0]      lock_mask,
  output logic [gpl_pkg::TOT_W-1:0]       locked_total,
  output logic [gpl_pkg::IDX_W-1:0]       dominant_index,
  output logic                            last_result,
  input  wire logic                       cfg_we,
  input  wire gpl_pkg::cfg_idx_t          cfg_index,
  input  wire logic [gpl_pkg::CFG_W-1:0]  cfg_data
);
  import gpl_pkg::*;

  localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CW = $clog2(MAX_MEMBERS + 1);
  localparam int PW = $clog2(MAX_GENES);

  state_t               state;
  state_t               state_next;
  logic [AW-1:0]        j;
  logic [AW-1:0]        ld_cnt;
  logic [CW-1:0]        n;
  logic [PW-1:0]        p;
  logic                 nopos;
  logic                 d_cnt;
  logic                 d_lock;
  logic [AW-1:0]        d_addr;
  logic [CFG_W-1:0]     pair_threshold;
  logic [CFG_W-1:0]     gene_count;

  logic [CFG_W-1:0]     g_eff;
  logic [PW-1:0]        p_last;
  logic                 j_last;
  logic                 ld_full;
  logic                 in_acc;
  logic                 closing;
  logic                 iss_cnt;
  logic                 iss_lock;
  logic                 iss_out;
  ctl_t                 ctl;
  logic [CW-1:0]        pair_count;
  logic [MAX_GENES-1:0] mask_q;
  logic [TOT_W-1:0]     total_q;
  logic [AW-1:0]        best;

  // Gene count clipped to the mask width, and the last pair position.
  always_comb begin
    g_eff   = (gene_count > CFG_W'(MAX_GENES)) ? CFG_W'(MAX_GENES) : gene_count;
    p_last  = PW'(g_eff - CFG_W'(2));
    j_last  = (CW'(j) == (n - CW'(1)));
    ld_full = (CW'(ld_cnt) == CW'(MAX_MEMBERS - 1));
    in_acc  = in_valid && !in_stall;
    closing = in_acc && (final_member || ld_full);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_threshold <= THRESHOLD_RESET;
      gene_count     <= GENE_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAIR_THRESHOLD: pair_threshold <= cfg_data;
        REG_GENE_COUNT:     gene_count     <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory issue strobes.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    iss_cnt    = 1'b0;
    iss_lock   = 1'b0;
    iss_out    = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        if (closing) begin
          state_next = (g_eff < CFG_W'(2)) ? S_OUT_RD : S_CNT;
        end
      end
      S_CNT: begin
        iss_cnt = 1'b1;
        if (j_last) begin
          state_next = S_CNT_DRAIN;
        end
      end
      S_CNT_DRAIN: begin
        state_next = S_LOCK;
      end
      S_LOCK: begin
        iss_lock = 1'b1;
        if (j_last) begin
          state_next = S_LOCK_DRAIN;
        end
      end
      S_LOCK_DRAIN: begin
        state_next = (p == p_last) ? S_OUT_RD : S_CNT;
      end
      S_OUT_RD: begin
        iss_out    = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = j_last ? S_LOAD : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Member, position and population counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      j      <= '0;
      ld_cnt <= '0;
      n      <= '0;
      p      <= '0;
      nopos  <= 1'b0;
      d_cnt  <= 1'b0;
      d_lock <= 1'b0;
    end else begin
      d_cnt  <= iss_cnt;
      d_lock <= iss_lock;
      if (in_acc) begin
        if (closing) begin
          ld_cnt <= '0;
          n      <= CW'(ld_cnt) + CW'(1);
          p      <= '0;
          j      <= '0;
          nopos  <= (g_eff < CFG_W'(2));
        end else begin
          ld_cnt <= ld_cnt + 1'b1;
        end
      end
      if (iss_cnt || iss_lock || (out_valid && !out_stall)) begin
        j <= j_last ? '0 : (j + 1'b1);
      end
      if ((state == S_LOCK_DRAIN) && (p != p_last)) begin
        p <= p + 1'b1;
      end
    end
  end

  // Address of the word in the data stage.
  always_ff @(posedge clk) begin
    d_addr <= j;
  end

  always_comb begin
    ctl.cnt_clr    = iss_cnt && (j == '0);
    ctl.cnt_en     = d_cnt;
    ctl.lock_en    = d_lock;
    ctl.first_pass = (p == '0);
    ctl.last_pass  = (p == p_last);
  end

  gpl_member_unit #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .AW(AW),
    .CW(CW),
    .PW(PW)
  ) u_member (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_acc),
    .wr_addr   (ld_cnt),
    .wr_data   (chromosome_bits),
    .rd_en     (iss_cnt || iss_lock),
    .rd_addr   (j),
    .ctl       (ctl),
    .pos       (p),
    .pair_count(pair_count)
  );

  gpl_mask_unit #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .MAX_GENES(MAX_GENES),
    .AW(AW),
    .CW(CW),
    .PW(PW)
  ) u_mask (
    .clk           (clk),
    .rd_en         (iss_lock || iss_out),
    .rd_addr       (j),
    .wr_addr       (d_addr),
    .ctl           (ctl),
    .pos           (p),
    .pair_count    (pair_count),
    .pair_threshold(pair_threshold),
    .mask_q        (mask_q),
    .total_q       (total_q),
    .best          (best)
  );

  // Result word, held steady by the registered read while it waits.
  always_comb begin
    member_index   = IDX_W'(j);
    lock_mask      = nopos ? '0 : DATA_W'(mask_q);
    locked_total   = nopos ? '0 : total_q;
    dominant_index = nopos ? '0 : IDX_W'(best);
    last_result    = j_last;
  end

  // Loading and result delivery never overlap.
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result word is pending");

  // The word that closes the population always leaves the loading state.
  a_close_leaves_load: assert property (@(posedge clk) disable iff (rst)
    closing |=> (state != S_LOAD))
    else $error("population closed but block kept loading");

  // A write-back never meets a read of the same mask entry.
  a_no_rmw_collision: assert property (@(posedge clk) disable iff (rst)
    (d_lock && (iss_lock || iss_out)) |-> (j != d_addr))
    else $error("mask read and write-back hit the same entry");

  // Every swept address lies inside the loaded population.
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (iss_cnt || iss_lock || iss_out) |-> (CW'(j) < n))
    else $error("sweep address beyond the population");

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
  import gpl_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 21;

  // One chromosome word as offered to the block.
  typedef struct {
    logic [DATA_W-1:0] bits;
    logic              fin;
  } chromosome_word_t;

  // One member's expected linkage mask and its companions.
  typedef struct {
    logic [IDX_W-1:0]  member;
    logic [DATA_W-1:0] mask;
    logic [TOT_W-1:0]  total;
    logic [IDX_W-1:0]  dominant;
    logic              last;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] chromosome_bits = '0;
  logic              final_member    = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [IDX_W-1:0]  member_index;
  logic [DATA_W-1:0] lock_mask;
  logic [TOT_W-1:0]  locked_total;
  logic [IDX_W-1:0]  dominant_index;
  logic              last_result;
  logic              cfg_we          = 1'b0;
  cfg_idx_t          cfg_index       = REG_PAIR_THRESHOLD;
  logic [CFG_W-1:0]  cfg_data        = '0;

  // Stimulus and prediction state.
  chromosome_word_t  chromosome_queue [$];
  logic [DATA_W-1:0] population [$];
  lock_result_t      expected_locks [$];
  logic [CFG_W-1:0]  threshold_copy  = THRESHOLD_RESET;
  logic [CFG_W-1:0]  gene_count_copy = GENE_COUNT_RESET;

  logic word_taken = 1'b0;
  logic quiet      = 1'b0;
  int   words_queued   = 0;
  int   words_accepted = 0;
  int   results_seen   = 0;
  int   populations    = 0;
  int   largest_pop    = 0;
  int   settings_used  = 0;
  int   errors         = 0;
  int   cycles         = 0;
  int   send_gap       = 0;
  int   stall_left     = 0;

  gene_pair_linkage_mask DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .chromosome_bits(chromosome_bits),
    .final_member   (final_member),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .member_index   (member_index),
    .lock_mask      (lock_mask),
    .locked_total   (locked_total),
    .dominant_index (dominant_index),
    .last_result    (last_result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the masks of the closed population and queues one result per member.
  function automatic void compute_locks();
    logic [DATA_W-1:0] masks [MAX_MEMBERS_DEF];
    logic [TOT_W-1:0]  totals [MAX_MEMBERS_DEF];
    int unsigned       tally [4];
    int                genes;
    int                n;
    int                best;
    logic [1:0]        pat;
    lock_result_t      r;
    n = population.size();
    genes = (gene_count_copy > MAX_GENES_DEF) ? MAX_GENES_DEF : int'(gene_count_copy);
    for (int j = 0; j < MAX_MEMBERS_DEF; j++) begin
      masks[j]  = '0;
      totals[j] = '0;
    end
    // Each adjacent gene pair: tally the patterns, then lock the members that qualify.
    for (int p = 0; p + 1 < genes; p++) begin
      for (int k = 0; k < 4; k++) tally[k] = 0;
      for (int j = 0; j < n; j++) begin
        pat = {population[j][p], population[j][p+1]};
        tally[pat]++;
      end
      for (int j = 0; j < n; j++) begin
        pat = {population[j][p], population[j][p+1]};
        if (!masks[j][p] && tally[pat] >= threshold_copy) begin
          masks[j]  = masks[j] | (64'd3 << p);
          totals[j] = totals[j] + 7'd2;
        end
      end
    end
    best = 0;
    for (int j = 1; j < n; j++) begin
      if (totals[j] > totals[best]) best = j;
    end
    for (int j = 0; j < n; j++) begin
      r.member   = j[IDX_W-1:0];
      r.mask     = masks[j];
      r.total    = totals[j];
      r.dominant = best[IDX_W-1:0];
      r.last     = (j + 1 == n);
      expected_locks.insert(expected_locks.size(), r);
    end
    populations++;
    if (n > largest_pop) largest_pop = n;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Word driver: presents queued words at the falling edge, with short idle bursts.
  always @(negedge clk) begin : drive_words
    logic              nv;
    logic [DATA_W-1:0] nb;
    logic              nf;
    chromosome_word_t  w;
    nv = in_valid;
    nb = chromosome_bits;
    nf = final_member;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && word_taken) nv = 1'b0;
      if (!nv && chromosome_queue.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 2);
        end else begin
          w  = chromosome_queue.pop_front();
          nv = 1'b1;
          nb = w.bits;
          nf = w.fin;
        end
      end
    end
    in_valid        <= nv;
    chromosome_bits <= nb;
    final_member    <= nf;
  end

  // Result stall: random bursts, none in the quiet phase.
  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: checks each accepted result, then feeds each accepted word to the predictor.
  always @(posedge clk) begin : watch_ports
    lock_result_t r;
    word_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_locks.size() == 0) begin
        $display("%0t: result with nothing expected: member %0d mask %h total %0d",
                 $time, member_index, lock_mask, locked_total);
        errors++;
      end else begin
        r = expected_locks.pop_front();
        check_field("member_index", r.member, member_index);
        check_field("lock_mask", r.mask, lock_mask);
        check_field("locked_total", r.total, locked_total);
        check_field("dominant_index", r.dominant, dominant_index);
        check_field("last_result", r.last, last_result);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      words_accepted++;
      population.insert(population.size(), chromosome_bits);
      if (final_member || population.size() == MAX_MEMBERS_DEF) begin
        compute_locks();
        population.delete();
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_locks.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic add_word(input logic [DATA_W-1:0] bits, input logic fin);
    chromosome_word_t w;
    w.bits = bits;
    w.fin  = fin;
    chromosome_queue.insert(chromosome_queue.size(), w);
    words_queued++;
  endtask

  function automatic logic [DATA_W-1:0] random_bits();
    return {$urandom, $urandom};
  endfunction

  // Builds a member word: fully random, or around shared bases so that pattern counts can reach the threshold.
  function automatic logic [DATA_W-1:0] make_chromosome(input int style,
                                                       input logic [DATA_W-1:0] base_a,
                                                       input logic [DATA_W-1:0] base_b);
    logic [DATA_W-1:0] sparse;
    sparse = random_bits() & random_bits() & random_bits();
    case (style)
      0: return random_bits();
      1: return base_a ^ sparse;
      2: return ($urandom_range(0, 1) ? base_a : base_b) ^ sparse;
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return base_a;
          default: return ~base_a;
        endcase
      end
    endcase
  endfunction

  task automatic add_population(input int n, input logic flag_last);
    int                style;
    logic [DATA_W-1:0] base_a;
    logic [DATA_W-1:0] base_b;
    style  = $urandom_range(0, 3);
    base_a = random_bits();
    base_b = random_bits();
    for (int i = 0; i < n; i++) begin
      add_word(make_chromosome(style, base_a, base_b), (i == n - 1) ? flag_last : 1'b0);
    end
  endtask

  // Waits until every word is taken and every result is in, then lets the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != words_queued || expected_locks.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_PAIR_THRESHOLD) threshold_copy = value;
    else gene_count_copy = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] genes);
    write_reg(REG_PAIR_THRESHOLD, thr);
    write_reg(REG_GENE_COUNT, genes);
    settings_used++;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] genes;
    int               phase_words;
    int               n;
    int               pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, a single member and the extreme words.
    settings_used++;
    add_word('1, 1'b1);
    add_word('0, 1'b0);
    add_word('1, 1'b0);
    add_word({16{4'hA}}, 1'b0);
    add_word({16{4'h5}}, 1'b1);
    wait_drained();

    // Threshold zero with the smallest gene count that has a pair.
    set_config(7'd0, 7'd2);
    add_word(random_bits(), 1'b0);
    add_word(random_bits(), 1'b1);
    wait_drained();

    // Threshold above the population size, gene count beyond the maximum.
    set_config(7'd64, 7'd127);
    add_word('0, 1'b0);
    add_word('0, 1'b0);
    add_word('0, 1'b1);
    wait_drained();

    // Gene counts that leave no pair positions.
    set_config(7'd1, 7'd0);
    add_word('1, 1'b1);
    wait_drained();
    set_config(7'd0, 7'd1);
    add_word('1, 1'b0);
    add_word('0, 1'b1);
    wait_drained();

    // Overlapping pairs: a gene locked at one position is skipped at the next.
    set_config(7'd2, 7'd64);
    add_word({8{8'h0F}}, 1'b0);
    add_word({8{8'h0F}}, 1'b0);
    add_word({8{8'hF0}}, 1'b1);
    wait_drained();

    // Widest threshold value with a gene count just over the maximum.
    set_config(7'd127, 7'd65);
    add_word('1, 1'b0);
    add_word('1, 1'b1);
    wait_drained();

    // Random phases: fresh settings, then populations of mostly small size.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0: thr = 7'd0;
        1: thr = 7'($urandom_range(65, 127));
        2: thr = 7'($urandom_range(0, 64));
        default: thr = 7'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0: genes = 7'($urandom_range(0, 1));
        1: genes = 7'($urandom_range(65, 127));
        2: genes = 7'd2;
        3: genes = 7'd64;
        default: genes = 7'($urandom_range(2, 64));
      endcase
      set_config(thr, genes);
      if (phase == RANDOM_PHASES - 1) quiet <= 1'b1;
      phase_words = 0;
      // A full store closes the population on its own, with or without the flag.
      if (phase == 3 || phase == 7) begin
        add_population(MAX_MEMBERS_DEF, phase == 7);
        phase_words += MAX_MEMBERS_DEF;
      end
      while (phase_words < PHASE_WORDS) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          n = $urandom_range(1, 6);
        end else if (pick < 19) begin
          n = $urandom_range(7, 16);
        end else begin
          n = $urandom_range(17, 24);
        end
        add_population(n, 1'b1);
        phase_words += n;
      end
      wait_drained();
    end

    repeat (40) @(negedge clk);
    $display("covered %0d populations (largest %0d members) over %0d register settings",
             populations, largest_pop, settings_used);
    $display("%0d words accepted, %0d results checked, %0d mismatches",
             words_accepted, results_seen, errors);
    if (errors == 0 && expected_locks.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### gene_pair_linkage_mask.f
src/gpl_pkg.sv
src/gpl_member_unit.sv
src/gpl_mask_unit.sv
src/gene_pair_linkage_mask.sv
sim/testbench.sv
